@@ hw/rtl/tmfs_pkg.sv @@
// Shared types and constants for the trimmed-mean frame time smoother.
// No dependencies; imported by tmfs_alu, tmfs_window and the top level.
package tmfs_pkg;

	localparam int STEP_W = 32;
	localparam int WLEN_W = 6;
	localparam int OUTL_W = 4;
	localparam int RATE_W = 17;
	localparam int ALU_W = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd8;
	localparam logic [OUTL_W-1:0] OUTL_RESET = 4'd1;
	localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH = 2'd0,
		CFG_OUTLIER_COUNT = 2'd1,
		CFG_BLEND_RATE    = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] result;
		logic             borrow;
		logic             zero;
	} alu_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMP,
		ST_ADD,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/tmfs_alu.sv @@
// Shared add/subtract unit used for ranking compares, summing, division and
// shift-add multiplication. Depends on tmfs_pkg.
module tmfs_alu (
	input  logic [tmfs_pkg::ALU_W-1:0] a,
	input  logic [tmfs_pkg::ALU_W-1:0] b,
	input  tmfs_pkg::alu_op_t          op,
	output tmfs_pkg::alu_flags_t       flags
);
	import tmfs_pkg::*;

	logic [ALU_W:0] wide;

	// one adder; borrow is the extra top bit of the subtraction
	always_comb begin
		if (op == ALU_SUB) begin
			wide = {1'b0, a} - {1'b0, b};
		end else begin
			wide = {1'b0, a} + {1'b0, b};
		end
		flags.result = wide[ALU_W-1:0];
		flags.borrow = (op == ALU_SUB) ? wide[ALU_W] : 1'b0;
		flags.zero   = (wide[ALU_W-1:0] == '0);
	end

endmodule

@@ hw/rtl/tmfs_window.sv @@
// Sample shift line: pushes the newest sample in at the head and rotates the
// filled part so every sample passes the head in turn. Depends on tmfs_pkg.
module tmfs_window #(
	parameter int WINDOW_MAX = 32,
	parameter int LEN_W = 6
) (
	input  logic                        clk,
	input  logic                        push,
	input  logic [tmfs_pkg::STEP_W-1:0] push_data,
	input  logic [LEN_W-1:0]            len,
	input  logic                        rotate,
	input  logic [LEN_W-1:0]            fill,
	output logic [tmfs_pkg::STEP_W-1:0] head
);
	import tmfs_pkg::*;

	logic [STEP_W-1:0] win_q [WINDOW_MAX];

	// shift within the window length, or rotate within the fill count
	always_ff @(posedge clk) begin
		for (int k = 0; k < WINDOW_MAX; k++) begin
			if (push) begin
				if (k == 0) begin
					win_q[k] <= push_data;
				end else if (k < int'(len)) begin
					win_q[k] <= win_q[k-1];
				end
			end else if (rotate) begin
				if (k == int'(fill) - 1) begin
					win_q[k] <= win_q[0];
				end else if (k < int'(fill) - 1) begin
					win_q[k] <= win_q[(k + 1) % WINDOW_MAX];
				end
			end
		end
	end

	assign head = win_q[0];

endmodule

@@ hw/rtl/trimmed_mean_frame_time_smoother.sv @@
// Top level of the frame time smoother: sequencer, registers and stream ports.
// Depends on tmfs_pkg, tmfs_alu and tmfs_window.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata[31:0] frame_ns
// m_axis    out        m_axis_tvalid/tready        tdata[31:0] step_ns, tuser smoothing_applied
// cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// Passthrough request: idle goes straight to the done state, which loads the output
// register. Smoothed request: load, compare, add, divide and multiply states, the
// shared adder doing one compare, add, divide step or multiply step per cycle. A
// result waits in the output register; the next request is taken while it waits.
// Reset empties the window, no clearing pass.
module trimmed_mean_frame_time_smoother #(
	parameter int WINDOW_MAX = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [tmfs_pkg::STEP_W-1:0]         s_axis_tdata,  // [31:0] frame_ns
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [tmfs_pkg::STEP_W-1:0]         m_axis_tdata,  // [31:0] step_ns
	output logic                                m_axis_tuser,  // [0] smoothing_applied
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tmfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tmfs_pkg::*;

	localparam int LEN_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = STEP_W + $clog2(WINDOW_MAX);
	localparam int BIT_W = $clog2(SUM_W);

	state_t state_q, state_d;

	logic [WLEN_W-1:0] wl_q;
	logic [OUTL_W-1:0] oc_q;
	logic [RATE_W-1:0] rate_q;

	logic [LEN_W-1:0]  fill_q, hidx_q, cidx_q, rank_q, step_q, cand_cnt_q;
	logic [STEP_W-1:0] frame_q, cand_q;
	logic [SUM_W-1:0]  sum_q, dq_q;
	logic [LEN_W-1:0]  rem_q;
	logic [ALU_W-1:0]  acc_q, mcand_q;
	logic [RATE_W-1:0] mplier_q;
	logic [BIT_W-1:0]  bit_q;
	logic              pass_q;
	logic [STEP_W-1:0] res_step_q;
	logic              res_applied_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] out_step_q;
	logic              out_applied_q;

	logic [LEN_W-1:0]  eff_len, fill_next, kept, hidx_next;
	logic [LEN_W:0]    fill_inc, trial;
	logic [RATE_W-1:0] rate_sat;
	logic              in_acc, smooth_go, less, keep, out_free, rotate;
	logic [STEP_W-1:0] head;
	logic [ALU_W-1:0]  alu_a, alu_b;
	alu_op_t           alu_op;
	alu_flags_t        alu_flags;
	logic [SUM_W-1:0]  q_next;
	logic [ALU_W-1:0]  acc_next;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_step_q;
	assign m_axis_tuser  = out_applied_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// effective window length, fill count update and smoothing decision
	always_comb begin
		if (wl_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(wl_q) > WINDOW_MAX) begin
			eff_len = LEN_W'(WINDOW_MAX);
		end else begin
			eff_len = LEN_W'(wl_q);
		end
		fill_inc  = {1'b0, fill_q} + (LEN_W+1)'(1);
		fill_next = (fill_inc > {1'b0, eff_len}) ? eff_len : fill_inc[LEN_W-1:0];
		smooth_go = int'(fill_next) >= 2 * int'(oc_q) + 1;
		kept      = LEN_W'(int'(fill_q) - 2 * int'(oc_q));
		rate_sat  = (rate_q > RATE_ONE) ? RATE_ONE : rate_q;
		hidx_next = (hidx_q == fill_q - LEN_W'(1)) ? '0 : hidx_q + LEN_W'(1);
		keep      = (int'(rank_q) >= int'(oc_q)) &&
		            (int'(rank_q) < int'(fill_q) - int'(oc_q));
		trial     = {rem_q, dq_q[SUM_W-1]};
	end

	tmfs_window #(
		.WINDOW_MAX (WINDOW_MAX),
		.LEN_W      (LEN_W)
	) u_window (
		.clk       (clk),
		.push      (in_acc),
		.push_data (s_axis_tdata),
		.len       (eff_len),
		.rotate    (rotate),
		.fill      (fill_q),
		.head      (head)
	);

	tmfs_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.op    (alu_op),
		.flags (alu_flags)
	);

	// next state and shared unit operand selection
	always_comb begin
		state_d = state_q;
		alu_a   = '0;
		alu_b   = '0;
		alu_op  = ALU_ADD;
		rotate  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = smooth_go ? ST_LOAD : ST_DONE;
				end
			end
			ST_LOAD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				alu_a  = ALU_W'(head);
				alu_b  = ALU_W'(cand_q);
				alu_op = ALU_SUB;
				rotate = 1'b1;
				if (step_q == fill_q - LEN_W'(1)) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				alu_a  = ALU_W'(sum_q);
				alu_b  = ALU_W'(cand_q);
				rotate = 1'b1;
				state_d = (cand_cnt_q == fill_q - LEN_W'(1)) ? ST_DIV : ST_LOAD;
			end
			ST_DIV: begin
				alu_a  = ALU_W'(trial);
				alu_b  = ALU_W'(kept);
				alu_op = ALU_SUB;
				if (bit_q == BIT_W'(SUM_W - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				alu_a = acc_q;
				alu_b = mcand_q;
				if (bit_q == BIT_W'(RATE_W - 1) && pass_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign less     = alu_flags.borrow || (alu_flags.zero && (hidx_q < cidx_q));
	assign q_next   = {dq_q[SUM_W-2:0], ~alu_flags.borrow};
	assign acc_next = mplier_q[0] ? alu_flags.result : acc_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, fill count, head index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= WLEN_RESET;
			oc_q        <= OUTL_RESET;
			rate_q      <= RATE_RESET;
			fill_q      <= '0;
			hidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_LENGTH: wl_q   <= cfg_data[WLEN_W-1:0];
					CFG_OUTLIER_COUNT: oc_q   <= cfg_data[OUTL_W-1:0];
					CFG_BLEND_RATE:    rate_q <= cfg_data[RATE_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_acc) begin
				fill_q <= fill_next;
				hidx_q <= '0;
			end else if (rotate) begin
				hidx_q <= hidx_next;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					frame_q       <= s_axis_tdata;
					sum_q         <= '0;
					cand_cnt_q    <= '0;
					res_step_q    <= s_axis_tdata;
					res_applied_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				cand_q <= head;
				cidx_q <= hidx_q;
				rank_q <= '0;
				step_q <= '0;
			end
			ST_CMP: begin
				if (less) begin
					rank_q <= rank_q + LEN_W'(1);
				end
				step_q <= step_q + LEN_W'(1);
			end
			ST_ADD: begin
				if (keep) begin
					sum_q <= alu_flags.result[SUM_W-1:0];
				end
				cand_cnt_q <= cand_cnt_q + LEN_W'(1);
				dq_q       <= keep ? alu_flags.result[SUM_W-1:0] : sum_q;
				rem_q      <= '0;
				bit_q      <= '0;
			end
			ST_DIV: begin
				rem_q <= alu_flags.borrow ? trial[LEN_W-1:0] : alu_flags.result[LEN_W-1:0];
				dq_q  <= q_next;
				if (bit_q == BIT_W'(SUM_W - 1)) begin
					acc_q    <= '0;
					mcand_q  <= ALU_W'(q_next[STEP_W-1:0]);
					mplier_q <= rate_sat;
					pass_q   <= 1'b0;
					bit_q    <= '0;
				end else begin
					bit_q <= bit_q + BIT_W'(1);
				end
			end
			ST_MUL: begin
				acc_q <= acc_next;
				if (bit_q == BIT_W'(RATE_W - 1)) begin
					// second pass weights the newest sample by one minus the rate
					mcand_q       <= ALU_W'(frame_q);
					mplier_q      <= RATE_ONE - rate_sat;
					pass_q        <= 1'b1;
					bit_q         <= '0;
					res_step_q    <= acc_next[16 +: STEP_W];
					res_applied_q <= 1'b1;
				end else begin
					mcand_q  <= {mcand_q[ALU_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[RATE_W-1:1]};
					bit_q    <= bit_q + BIT_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_step_q    <= res_step_q;
					out_applied_q <= res_applied_q;
				end
			end
			default: begin
			end
		endcase
	end

	// the rotations of one smoothed request leave the window as it was
	a_ring_restored: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> hidx_q == '0)
		else $error("window rotation not restored");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= WINDOW_MAX)
		else $error("fill count beyond window");

	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !smooth_go |=> state_q == ST_DONE && !res_applied_q)
		else $error("passthrough request did not finish directly");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < kept)
		else $error("division remainder out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> int'(fill_q) >= 2 * int'(oc_q) + 1)
		else $error("ranking started without enough samples");

endmodule

@@ tb/sv/tb_trimmed_mean_frame_time_smoother.sv @@
// Self-checking bench for the trimmed-mean frame time smoother: frame durations in,
// smoothed steps out, predicted per request and compared in order.
// Depends on tmfs_pkg and the trimmed_mean_frame_time_smoother RTL.
module tb_trimmed_mean_frame_time_smoother;
	timeunit 1ns;
	timeprecision 1ps;

	import tmfs_pkg::*;

	localparam int unsigned WIN_MAX = 32;
	localparam int unsigned FRAME_TOTAL = 1950;
	localparam int unsigned CYCLE_LIMIT = 20_000_000;
	// longest smoothed request at a full window, plus margin
	localparam int unsigned SETTLE_CYCLES = 1300;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

	typedef enum {REQ_FRAME, REQ_REG, REQ_DRAIN} req_kind_t;

	typedef struct {
		req_kind_t               kind;
		logic [STEP_W-1:0]       frame;
		logic [CFG_IDX_W-1:0]    index;
		logic [CFG_DATA_W-1:0]   data;
	} src_req_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              applied;
	} step_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [STEP_W-1:0]       s_axis_tdata = '0;    // [31:0] frame_ns
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [STEP_W-1:0]       m_axis_tdata;         // [31:0] step_ns
	logic                    m_axis_tuser;         // [0] smoothing_applied
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// mirror of the block's state and registers, reset values
	logic [STEP_W-1:0]       win_samples [WIN_MAX] = '{default: '0};
	int unsigned             win_fill = 0;
	logic [WLEN_W-1:0]       cur_wlen = WLEN_RESET;
	logic [OUTL_W-1:0]       cur_outl = OUTL_RESET;
	logic [RATE_W-1:0]       cur_rate = RATE_RESET;

	src_req_t                pending [$];
	step_result_t            expected_steps [$];
	int unsigned             frames_queued = 0;
	int                      fail_count = 0;
	int unsigned             cycle_count = 0;

	src_req_t                req;
	int unsigned             src_gap = 0;
	int unsigned             src_quiet = 0;
	bit                      src_hold = 1'b0;
	int unsigned             sink_stall = 0;
	int unsigned             sink_quiet = 0;
	step_result_t            want;

	trimmed_mean_frame_time_smoother #(
		.WINDOW_MAX(WIN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// idle length: mostly short, a few long, with quiet stretches of none at all
	function automatic int unsigned pick_gap(inout int unsigned quiet);
		int unsigned r;
		if (quiet != 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(59) == 0) begin
			quiet = $urandom_range(30, 100);
			return 0;
		end
		r = $urandom_range(99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic int unsigned active_length();
		if (cur_wlen == 0)
			return 1;
		if (cur_wlen > WIN_MAX)
			return WIN_MAX;
		return cur_wlen;
	endfunction

	function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			CFG_WINDOW_LENGTH: cur_wlen = value[WLEN_W-1:0];
			CFG_OUTLIER_COUNT: cur_outl = value[OUTL_W-1:0];
			CFG_BLEND_RATE:    cur_rate = value[RATE_W-1:0];
			default: ;
		endcase
	endfunction

	// shift the frame in, then trimmed mean blended with the frame, or passthrough
	function automatic void smooth_frame(input logic [STEP_W-1:0] frame);
		logic [STEP_W-1:0] ordered [WIN_MAX];
		logic [STEP_W-1:0] key;
		logic [63:0]       total;
		logic [63:0]       rate;
		logic [63:0]       mix;
		int unsigned       len;
		int unsigned       kept;
		int unsigned       i;
		int unsigned       j;
		step_result_t      res;
		len = active_length();
		for (i = len - 1; i > 0; i--)
			win_samples[i] = win_samples[i-1];
		win_samples[0] = frame;
		win_fill = (win_fill + 1 > len) ? len : win_fill + 1;
		res.step = frame;
		res.applied = 1'b0;
		if (win_fill >= 2 * cur_outl + 1) begin
			for (i = 0; i < win_fill; i++)
				ordered[i] = win_samples[i];
			for (i = 1; i < win_fill; i++) begin
				key = ordered[i];
				j = i;
				while (j > 0 && ordered[j-1] > key) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = key;
			end
			kept = win_fill - 2 * cur_outl;
			total = '0;
			for (i = 0; i < kept; i++)
				total += ordered[cur_outl + i];
			rate = (cur_rate > RATE_ONE) ? 64'(RATE_ONE) : 64'(cur_rate);
			mix = rate * (total / kept) + (64'(RATE_ONE) - rate) * 64'(frame);
			res.step = mix[47:16];
			res.applied = 1'b1;
		end
		expected_steps.push_back(res);
	endfunction

	// frame times around a refresh period, with spikes, dips, noise and extremes
	function automatic logic [STEP_W-1:0] next_frame(input int unsigned base);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return base - base / 16 + $urandom_range(base / 8);
		if (r < 65)
			return base * $urandom_range(2, 6);
		if (r < 70)
			return $urandom_range(base / 4);
		if (r < 88)
			return $urandom();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return 32'h0000_0001;
			3: return 32'hFFFF_FFFE;
			default: return 32'h8000_0000;
		endcase
	endfunction

	task automatic push_frame(input logic [STEP_W-1:0] frame);
		src_req_t r;
		r.kind = REQ_FRAME;
		r.frame = frame;
		r.index = '0;
		r.data = '0;
		pending.push_back(r);
		frames_queued++;
	endtask

	task automatic push_drain();
		src_req_t r;
		r.kind = REQ_DRAIN;
		r.frame = '0;
		r.index = '0;
		r.data = '0;
		pending.push_back(r);
	endtask

	// unused upper data bits sometimes carry junk the block must ignore
	task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
			input int unsigned width);
		src_req_t    r;
		int unsigned d;
		d = value;
		if (width < CFG_DATA_W && $urandom_range(3) == 0)
			d = d | ($urandom() << width);
		r.kind = REQ_REG;
		r.frame = '0;
		r.index = idx;
		r.data = d[CFG_DATA_W-1:0];
		pending.push_back(r);
	endtask

	// wait for idle, write the chosen registers, then a run of frames
	task automatic queue_phase(input int unsigned wl, input int unsigned ol,
			input int unsigned rt, input int unsigned n, input int unsigned base,
			input logic [2:0] wr, input bit spare);
		int unsigned k;
		push_drain();
		if (spare)
			push_reg(CFG_IDX_UNUSED, $urandom(), 0);
		if (wr[0])
			push_reg(CFG_WINDOW_LENGTH, wl, WLEN_W);
		if (wr[1])
			push_reg(CFG_OUTLIER_COUNT, ol, OUTL_W);
		if (wr[2])
			push_reg(CFG_BLEND_RATE, rt, RATE_W);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(99) == 0)
				push_drain();
			push_frame(next_frame(base));
		end
	endtask

	// source side: frames and register writes from the pending queue
	always @(posedge clk or negedge arst_n) begin
		bit frame_go;
		bit reg_go;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				smooth_frame(s_axis_tdata);
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (!((s_axis_tvalid && !s_axis_tready) || (cfg_valid && !cfg_ready))) begin
				frame_go = 1'b0;
				reg_go = 1'b0;
				if (src_gap != 0) begin
					src_gap--;
				end else if (src_hold) begin
					src_hold = (expected_steps.size() != 0);
				end else if (pending.size() != 0) begin
					req = pending.pop_front();
					case (req.kind)
						REQ_FRAME: begin
							frame_go = 1'b1;
							s_axis_tdata <= req.frame;
							src_gap = pick_gap(src_quiet);
						end
						REQ_REG: begin
							reg_go = 1'b1;
							cfg_index <= req.index;
							cfg_data <= req.data;
						end
						default: src_hold = 1'b1;
					endcase
				end
				s_axis_tvalid <= frame_go;
				cfg_valid <= reg_go;
			end
		end
	end

	// result side: compare with the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_steps.size() == 0) begin
					$display("%0t: result with none pending: step_ns %h smoothing_applied %b",
						$time, m_axis_tdata, m_axis_tuser);
					fail_count++;
				end else begin
					want = expected_steps.pop_front();
					if (m_axis_tdata !== want.step) begin
						$display("%0t: step_ns expected %h actual %h",
							$time, want.step, m_axis_tdata);
						fail_count++;
					end
					if (m_axis_tuser !== want.applied) begin
						$display("%0t: smoothing_applied expected %b actual %b",
							$time, want.applied, m_axis_tuser);
						fail_count++;
					end
				end
				sink_stall = pick_gap(sink_quiet);
			end
			// stall only counts down while a result is offered
			m_axis_tready <= (sink_stall == 0);
			if (m_axis_tvalid && sink_stall != 0)
				sink_stall--;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned base;
		int unsigned wl;
		int unsigned eff;
		int unsigned ol;
		int unsigned rt;
		int unsigned n;
		int unsigned r;
		int unsigned k;

		// reset register values: extremes, bit patterns, steady frames and a spike
		push_frame('0);
		push_frame('1);
		push_frame(32'h8000_0000);
		push_frame(32'h0000_0001);
		for (k = 0; k < 4; k++)
			push_frame('1);
		push_frame(32'h5555_5555);
		push_frame(32'hAAAA_AAAA);
		push_frame(32'h7FFF_FFFF);
		for (k = 0; k < 5; k++)
			push_frame(32'd16_666_667);
		push_frame(32'd100_000_000);
		for (k = 0; k < 4; k++)
			push_frame(32'd16_666_667 + k * 1000);

		// zero length acts as one, blend rate above one saturates
		queue_phase(0, 0, 131071, 8, 16_666_667, 3'b111, 1'b0);
		// length above the maximum saturates, widest trim
		queue_phase(63, 15, 65536, 36, 8_333_333, 3'b111, 1'b0);
		// window lowered with a full fill count
		queue_phase(4, 1, 0, 10, 16_666_667, 3'b111, 1'b0);
		// unused register index ignored, then full window with no trim
		queue_phase(32, 0, 1, 40, 33_333_333, 3'b111, 1'b1);
		// four outliers trimmed each side of a nine-sample window, one sample kept
		queue_phase(9, 4, 20000, 12, 6_944_444, 3'b111, 1'b0);
		// too many outliers for the window: passthrough throughout
		queue_phase(6, 15, 40000, 10, 16_666_667, 3'b111, 1'b0);

		// random settings, mostly short windows
		while (frames_queued < FRAME_TOTAL) begin
			r = $urandom_range(99);
			if (r < 65)
				wl = $urandom_range(1, 8);
			else if (r < 85)
				wl = $urandom_range(9, 16);
			else if (r < 92)
				wl = $urandom_range(17, 32);
			else if ($urandom_range(1) == 0)
				wl = 0;
			else
				wl = $urandom_range(33, 63);
			eff = (wl == 0) ? 1 : (wl > WIN_MAX) ? WIN_MAX : wl;
			if ($urandom_range(9) == 0)
				ol = $urandom_range(15);
			else
				ol = $urandom_range((eff - 1) / 2 > 15 ? 15 : (eff - 1) / 2);
			case ($urandom_range(7))
				0: rt = 0;
				1: rt = 65536;
				2: rt = $urandom_range(65537, 131071);
				default: rt = $urandom_range(65535);
			endcase
			case ($urandom_range(6))
				0: base = 4_166_667;
				1: base = 6_944_444;
				2: base = 8_333_333;
				3: base = 16_666_667;
				4: base = 33_333_333;
				5: base = 50_000_000;
				default: base = $urandom_range(1000, 100_000_000);
			endcase
			n = (eff > 16) ? $urandom_range(8, 20) : $urandom_range(20, 80);
			queue_phase(wl, ol, rt, n, base, 3'($urandom_range(1, 7)),
				$urandom_range(9) == 0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_axis_tvalid || cfg_valid
				|| expected_steps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/tmfs_pkg.sv
hw/rtl/tmfs_alu.sv
hw/rtl/tmfs_window.sv
hw/rtl/trimmed_mean_frame_time_smoother.sv
tb/sv/tb_trimmed_mean_frame_time_smoother.sv
